// ===== design/als_pkg.sv =====
package als_pkg;

  localparam int unsigned ALS_DEPTH = 64;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned ERR_W  = 3;

  // func, value, position, count packed, padded to whole bytes
  localparam int unsigned IN_FIELDS_W  = FUNC_W + WORD_W + POS_W + POS_W;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  // data, length_now, error packed, padded to whole bytes
  localparam int unsigned OUT_FIELDS_W = WORD_W + POS_W + ERR_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND     = 3'd0,
    FN_INSERT     = 3'd1,
    FN_REM_LAST   = 3'd2,
    FN_REM_COUNT  = 3'd3,
    FN_TRIM       = 3'd4,
    FN_READ_POS   = 3'd5,
    FN_READ_LAST  = 3'd6
  } func_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 3'd0,
    ERR_EMPTY     = 3'd1,
    ERR_RANGE     = 3'd2,
    ERR_REM_EMPTY = 3'd3,
    ERR_REM_MANY  = 3'd4,
    ERR_TRIM      = 3'd5,
    ERR_FULL      = 3'd6
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SHIFT,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

// ===== design/array_list_store.sv =====
// append, remove, trim and errors pass ST_EXEC then ST_DONE; reads pass ST_EXEC, ST_READ,
// ST_DONE; an insert below the length walks ST_SHIFT from the top word to the position,
// then ST_FILL, one word at a time through the single read and write port.
// a new item is taken only in ST_IDLE, once ST_DONE has registered the result.
// reset: rst_n (synchronous, active low) empties the list and clears the handshake state;
// the word store is not cleared, entries above the length are never read.
module array_list_store
  import als_pkg::*;
#(
  parameter int unsigned DEPTH = ALS_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // func [2:0], value [34:3], position [41:35], count [48:42], zero pad above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // data [31:0], length_now [38:32], error [41:39], zero pad above
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (LW > POS_W) ? LW : POS_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  state_t                 state_r, state_nxt;
  logic [LW-1:0]          len_r, len_nxt;
  func_t                  func_r, func_nxt;
  logic [WORD_W-1:0]      value_r, value_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [POS_W-1:0]       count_r, count_nxt;
  logic [AW-1:0]          rd_idx_r, rd_idx_nxt;
  logic [WORD_W-1:0]      res_data_r, res_data_nxt;
  err_t                   res_err_r, res_err_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [CW-1:0] len_x, pos_x, cnt_x;
  logic [LW-1:0] len_m1;
  logic [AW-1:0] pos_addr;
  logic          full, empty;

  assign len_x    = CW'(len_r);
  assign pos_x    = CW'(pos_r);
  assign cnt_x    = CW'(count_r);
  assign len_m1   = len_r - LW'(1);
  assign pos_addr = pos_x[AW-1:0];
  assign full     = (len_r == LW'(DEPTH));
  assign empty    = (len_r == '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      len_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    value_r     <= value_nxt;
    pos_r       <= pos_nxt;
    count_r     <= count_nxt;
    rd_idx_r    <= rd_idx_nxt;
    res_data_r  <= res_data_nxt;
    res_err_r   <= res_err_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    func_nxt       = func_r;
    value_nxt      = value_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    res_data_nxt   = res_data_r;
    res_err_nxt    = res_err_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    in_tready      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = len_r[AW-1:0];
    mem_wdata      = value_r;
    mem_raddr      = pos_addr;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          func_nxt  = func_t'(in_tdata[FUNC_W-1:0]);
          value_nxt = in_tdata[FUNC_W +: WORD_W];
          pos_nxt   = in_tdata[FUNC_W + WORD_W +: POS_W];
          count_nxt = in_tdata[FUNC_W + WORD_W + POS_W +: POS_W];
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_data_nxt = '0;
        res_err_nxt  = ERR_OK;
        state_nxt    = ST_DONE;
        case (func_r)
          FN_APPEND: begin
            if (full) begin
              res_err_nxt = ERR_FULL;
            end else begin
              mem_we  = 1'b1;
              len_nxt = len_r + LW'(1);
            end
          end
          FN_INSERT: begin
            if (full) begin
              res_err_nxt = ERR_FULL;
            end else if (pos_x > len_x) begin
              res_err_nxt = ERR_RANGE;
            end else if (pos_x == len_x) begin
              mem_we    = 1'b1;
              mem_waddr = pos_addr;
              len_nxt   = len_r + LW'(1);
            end else begin
              // walk down from the top, each word moves up one slot
              mem_raddr  = len_m1[AW-1:0];
              rd_idx_nxt = len_m1[AW-1:0];
              state_nxt  = ST_SHIFT;
            end
          end
          FN_REM_LAST: begin
            if (empty) begin
              res_err_nxt = ERR_REM_EMPTY;
            end else begin
              len_nxt = len_m1;
            end
          end
          FN_REM_COUNT: begin
            if (cnt_x > len_x) begin
              res_err_nxt = ERR_REM_MANY;
            end else begin
              len_nxt = LW'(len_x - cnt_x);
            end
          end
          FN_TRIM: begin
            if (cnt_x > len_x) begin
              res_err_nxt = ERR_TRIM;
            end else begin
              len_nxt = LW'(cnt_x);
            end
          end
          FN_READ_POS: begin
            if (empty) begin
              res_err_nxt = ERR_EMPTY;
            end else if (pos_x >= len_x) begin
              res_err_nxt = ERR_RANGE;
            end else begin
              mem_raddr = pos_addr;
              state_nxt = ST_READ;
            end
          end
          FN_READ_LAST: begin
            if (empty) begin
              res_err_nxt = ERR_EMPTY;
            end else begin
              mem_raddr = len_m1[AW-1:0];
              state_nxt = ST_READ;
            end
          end
          default: begin
            // unused code: no change, plain ok result
          end
        endcase
      end

      ST_READ: begin
        res_data_nxt = rd_q;
        state_nxt    = ST_DONE;
      end

      ST_SHIFT: begin
        // word read last cycle lands one slot higher
        mem_we    = 1'b1;
        mem_waddr = rd_idx_r + AW'(1);
        mem_wdata = rd_q;
        if (rd_idx_r == pos_addr) begin
          state_nxt = ST_FILL;
        end else begin
          mem_raddr  = rd_idx_r - AW'(1);
          rd_idx_nxt = rd_idx_r - AW'(1);
        end
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = pos_addr;
        len_nxt   = len_r + LW'(1);
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                            res_err_r, len_x[POS_W-1:0], res_data_r};
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
